// ===== rtl/irpwc_pkg.sv =====
// Shared types and constants for the IR pulse width capture block.
// No dependencies; imported by every module of the block.
package irpwc_pkg;

  localparam int unsigned BUFFER_DEPTH_DEFAULT = 128;

  localparam logic [15:0] GAP_TICKS_RESET   = 16'd500;
  localparam logic [7:0]  MAX_ENTRIES_RESET = 8'd88;
  localparam logic        MARK_LEVEL_RESET  = 1'b0;

  // Idle counter holds just below saturation
  localparam logic [15:0] IDLE_HOLD_TICKS = 16'd65534;
  localparam logic [15:0] IDLE_BACK_TICKS = 16'd65533;

  localparam int unsigned PADDR_W = 4;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_GAP_TICKS   = 2'd0;
  localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
  localparam logic [1:0] REG_MARK_LEVEL  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_GAP   = 2'd0;
  localparam logic [1:0] KIND_MARK  = 2'd1;
  localparam logic [1:0] KIND_SPACE = 2'd2;

  typedef struct packed {
    logic [15:0] gap_ticks;
    logic [7:0]  max_entries;
    logic        mark_level;
  } cfg_t;

  typedef struct packed {
    logic ir_level;
    logic rearm;
  } sample_t;

  typedef struct packed {
    logic [15:0] width_ticks;
    logic [6:0]  entry_index;
    logic [1:0]  width_kind;
    logic        frame_done;
    logic [7:0]  entry_count;
  } result_t;

endpackage

// ===== rtl/irpwc_cfg.sv =====
// APB-style register file for the IR pulse width capture block.
// Depends on irpwc_pkg (cfg_t, register indexes, reset values).
module irpwc_cfg
  import irpwc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_ticks   <= GAP_TICKS_RESET;
      cfg.max_entries <= MAX_ENTRIES_RESET;
      cfg.mark_level  <= MARK_LEVEL_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAP_TICKS:   cfg.gap_ticks   <= pwdata[15:0];
        REG_MAX_ENTRIES: cfg.max_entries <= pwdata[7:0];
        REG_MARK_LEVEL:  cfg.mark_level  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAP_TICKS:   prdata = {16'd0, cfg.gap_ticks};
      REG_MAX_ENTRIES: prdata = {24'd0, cfg.max_entries};
      REG_MARK_LEVEL:  prdata = {31'd0, cfg.mark_level};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/irpwc_core.sv =====
// Capture state machine, width buffer and result register.
// Depends on irpwc_pkg (phase_t, sample_t, result_t, cfg_t, constants).
module irpwc_core
  import irpwc_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [15:0] DEPTH16 = 16'(BUFFER_DEPTH);

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  stored_count, stored_count_next;

  logic [15:0] width_store [BUFFER_DEPTH];

  logic        accept;
  logic        is_mark;
  phase_t      ph_cur;
  logic [7:0]  sc_cur;
  logic [15:0] tc_inc;
  logic        full;
  logic        emit;
  logic        do_store;
  result_t     res_next;
  logic [AW-1:0] wr_addr;

  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;
  assign is_mark      = (sample.ir_level == cfg.mark_level);
  assign wr_addr      = AW'(sc_cur);

  always_comb begin
    ph_cur = sample.rearm ? PH_IDLE : phase;
    sc_cur = sample.rearm ? 8'd0 : stored_count;
    tc_inc = tick_count + 16'd1;
    full   = (sc_cur >= cfg.max_entries) || ({8'd0, sc_cur} >= DEPTH16);

    phase_next        = ph_cur;
    stored_count_next = sc_cur;
    tick_count_next   = tc_inc;
    emit              = 1'b0;
    do_store          = 1'b0;
    res_next          = '0;

    if (full && ph_cur != PH_STOP) begin
      phase_next           = PH_STOP;
      emit                 = 1'b1;
      res_next.frame_done  = 1'b1;
      res_next.entry_count = sc_cur;
    end else begin
      case (ph_cur)
        PH_IDLE: begin
          if (is_mark) begin
            if (tc_inc < cfg.gap_ticks) begin
              tick_count_next = 16'd0;
            end else begin
              // idle always holds a zero count, so the gap lands at entry 0
              phase_next          = PH_MARK;
              do_store            = 1'b1;
              res_next.width_kind = KIND_GAP;
            end
          end else if (tc_inc == IDLE_HOLD_TICKS) begin
            tick_count_next = IDLE_BACK_TICKS;
          end
        end
        PH_MARK: begin
          if (!is_mark) begin
            phase_next          = PH_SPACE;
            do_store            = 1'b1;
            res_next.width_kind = KIND_MARK;
          end
        end
        PH_SPACE: begin
          if (is_mark) begin
            phase_next          = PH_MARK;
            do_store            = 1'b1;
            res_next.width_kind = KIND_SPACE;
          end else if (tc_inc > cfg.gap_ticks) begin
            phase_next           = PH_STOP;
            emit                 = 1'b1;
            res_next.frame_done  = 1'b1;
            res_next.entry_count = sc_cur;
          end
        end
        default: begin
          if (is_mark) tick_count_next = 16'd0;
        end
      endcase

      if (do_store) begin
        emit                 = 1'b1;
        stored_count_next    = sc_cur + 8'd1;
        tick_count_next      = 16'd0;
        res_next.width_ticks = tc_inc;
        res_next.entry_index = sc_cur[6:0];
        res_next.entry_count = sc_cur + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= 16'd0;
      stored_count <= 8'd0;
    end else if (accept) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      stored_count <= stored_count_next;
    end
  end

  // store index is below the limit, hence inside the buffer
  always_ff @(posedge clk) begin
    if (accept && do_store) width_store[wr_addr] <= tc_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) result <= res_next;
  end

endmodule

// ===== rtl/ir_pulse_width_capture.sv =====
// Top level of the IR pulse width capture block.
// Depends on irpwc_pkg, irpwc_cfg and irpwc_core.
//
// Usage:
//  - sample channel (sample_valid/sample_ready/sample): one transaction per
//    receiver tick, carrying the sampled pin level and a rearm flag. Rearm
//    drops capture back to idle before that tick is handled.
//  - result channel (result_valid/result_ready/result): zero or one
//    transaction per tick, holding a stored mark or space width (or the
//    leading gap) with its buffer position, or a frame_done stop marker.
//  - APB-style port: gap_ticks at 0x0, max_entries at 0x4, mark_level at 0x8.
//    Write only while the block is idle; pready is tied high.
// Timing:
//  - one tick per clock sustained; the tick's whole update is one pass of
//    logic from the state registers into the result register.
//  - result_valid rises in the cycle after the sample is taken.
//  - the result register frees in the cycle it is taken, so sample_ready
//    stays high while results are drained each cycle. If the receiver stalls
//    with a result pending, sample_ready drops until it is taken.
// Reset (rst, synchronous): idle, counters zero, registers at their defaults.
// The width buffer holds no reset value; it is written only.
module ir_pulse_width_capture
  import irpwc_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  sample_t            sample,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;

  // Register file
  irpwc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Capture engine with its result register
  irpwc_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== tb/ir_pulse_width_capture_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ir_pulse_width_capture: directed table, then random frames.
// Depends on irpwc_pkg and the ir_pulse_width_capture RTL; needs no other files.
module ir_pulse_width_capture_tb;
  import irpwc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [7:0]  DEPTH_LIMIT  = 8'(BUFFER_DEPTH_DEFAULT);

  // How a directed row is checked: by the predictor, as "no transaction", or
  // against the result typed into the row.
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_TYPED
  } chk_e;

  typedef struct packed {
    logic    lvl;
    logic    rearm;
    chk_e    chk;
    result_t typed;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  sample_t            sample = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Register mirror and predictor state
  logic [15:0] cfg_gap = GAP_TICKS_RESET;
  logic [7:0]  cfg_max = MAX_ENTRIES_RESET;
  logic        cfg_mark = MARK_LEVEL_RESET;
  phase_t      cap_phase = PH_IDLE;
  logic [15:0] run_ticks = '0;
  logic [7:0]  entries_held = '0;

  result_t     due_captures[$];
  int unsigned samples_sent = 0;
  int unsigned captures_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  // Directed table: mark is level 0, gap 3 ticks, 4 entries per frame.
  // Typed rows are the leading gaps and the two kinds of stop.
  dir_row_t dir_rows [23] = '{
    '{1'b1, 1'b0, CHK_NONE,  '0},
    '{1'b1, 1'b0, CHK_NONE,  '0},
    '{1'b1, 1'b0, CHK_NONE,  '0},
    '{1'b0, 1'b0, CHK_TYPED, '{16'd4, 7'd0, KIND_GAP, 1'b0, 8'd1}},
    '{1'b0, 1'b0, CHK_PRED,  '0},
    '{1'b1, 1'b0, CHK_PRED,  '0},
    '{1'b0, 1'b0, CHK_PRED,  '0},
    '{1'b1, 1'b0, CHK_PRED,  '0},
    // entry count hits the limit: overflow stop
    '{1'b1, 1'b0, CHK_TYPED, '{16'd0, 7'd0, KIND_GAP, 1'b1, 8'd4}},
    '{1'b0, 1'b0, CHK_NONE,  '0},
    '{1'b1, 1'b0, CHK_NONE,  '0},
    '{1'b1, 1'b1, CHK_NONE,  '0},
    '{1'b1, 1'b0, CHK_NONE,  '0},
    '{1'b0, 1'b0, CHK_TYPED, '{16'd4, 7'd0, KIND_GAP, 1'b0, 8'd1}},
    '{1'b1, 1'b0, CHK_PRED,  '0},
    '{1'b1, 1'b0, CHK_NONE,  '0},
    '{1'b1, 1'b0, CHK_NONE,  '0},
    '{1'b1, 1'b0, CHK_NONE,  '0},
    // space outlasts the gap: end-of-frame stop
    '{1'b1, 1'b0, CHK_TYPED, '{16'd0, 7'd0, KIND_GAP, 1'b1, 8'd2}},
    '{1'b0, 1'b1, CHK_PRED,  '0},
    '{1'b1, 1'b1, CHK_PRED,  '0},
    // mark after too short a gap only clears the counter
    '{1'b0, 1'b0, CHK_PRED,  '0},
    '{1'b1, 1'b0, CHK_PRED,  '0}
  };

  ir_pulse_width_capture u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Builds the result for the running width at the next buffer slot and restarts the count
  function automatic bit store_width(input logic [1:0] kind, output result_t r);
    r.width_ticks = run_ticks;
    r.entry_index = entries_held[6:0];
    r.width_kind  = kind;
    r.frame_done  = 1'b0;
    entries_held  = entries_held + 8'd1;
    r.entry_count = entries_held;
    run_ticks     = '0;
    return 1'b1;
  endfunction

  // One receiver tick; returns 1 when the tick yields a transaction
  function automatic bit capture_tick(input sample_t s, output result_t r);
    logic       is_mark;
    logic [7:0] limit;
    is_mark = (s.ir_level == cfg_mark);
    limit   = (cfg_max > DEPTH_LIMIT) ? DEPTH_LIMIT : cfg_max;
    r       = '0;
    if (s.rearm) begin
      cap_phase    = PH_IDLE;
      entries_held = '0;
    end
    run_ticks = run_ticks + 16'd1;
    // buffer full (or zero limit): stop before anything else
    if (entries_held >= limit && cap_phase != PH_STOP) begin
      cap_phase     = PH_STOP;
      r.frame_done  = 1'b1;
      r.entry_count = entries_held;
      return 1'b1;
    end
    case (cap_phase)
      PH_IDLE: begin
        if (is_mark && run_ticks < cfg_gap) begin
          run_ticks = '0;
        end else if (is_mark) begin
          entries_held = '0;
          cap_phase    = PH_MARK;
          return store_width(KIND_GAP, r);
        end else if (run_ticks == IDLE_HOLD_TICKS) begin
          run_ticks = IDLE_BACK_TICKS;
        end
      end
      PH_MARK: begin
        if (!is_mark) begin
          cap_phase = PH_SPACE;
          return store_width(KIND_MARK, r);
        end
      end
      PH_SPACE: begin
        if (is_mark) begin
          cap_phase = PH_MARK;
          return store_width(KIND_SPACE, r);
        end
        if (run_ticks > cfg_gap) begin
          cap_phase     = PH_STOP;
          r.frame_done  = 1'b1;
          r.entry_count = entries_held;
          return 1'b1;
        end
      end
      default: begin
        if (is_mark) run_ticks = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_GAP_TICKS:   return {16'd0, cfg_gap};
      REG_MAX_ENTRIES: return {24'd0, cfg_max};
      default:         return {31'd0, cfg_mark};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------

  // Setup then access phase; called and returns on a falling edge, with psel low
  // before it returns, so back-to-back calls never touch psel twice in a step
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] rd;
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== reg_value(idx)) begin
      $error("register %0d: expected %0h, got %0h", idx, reg_value(idx), rd);
      mismatches++;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    case (idx)
      REG_GAP_TICKS:   cfg_gap  = value[15:0];
      REG_MAX_ENTRIES: cfg_max  = value[7:0];
      default:         cfg_mark = value[0];
    endcase
    check_reg(idx);
  endtask

  task automatic set_config(input logic [15:0] gap, input logic [7:0] max_n,
                            input logic mark);
    write_reg(REG_GAP_TICKS, {16'd0, gap});
    write_reg(REG_MAX_ENTRIES, {24'd0, max_n});
    write_reg(REG_MARK_LEVEL, {31'd0, mark});
  endtask

  // ---------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------

  // Offers one sample from a falling edge; returns on the falling edge after
  // the transaction, leaving valid high for a following call
  task automatic send_sample(input sample_t s, input chk_e chk, input result_t typed);
    result_t predicted;
    bit      has;
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    has = capture_tick(s, predicted);
    if (chk == CHK_TYPED) due_captures.push_back(typed);
    else if (chk == CHK_PRED && has) due_captures.push_back(predicted);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_level(input logic level, input int unsigned len,
                            input logic rearm_first);
    sample_t s;
    for (int unsigned i = 0; i < len; i++) begin
      s.ir_level = level;
      s.rearm    = rearm_first && (i == 0);
      send_sample(s, CHK_PRED, '0);
    end
  endtask

  // Mostly well-formed frames (rearm, gap, mark/space pairs, closing space)
  // with random widths; a share of short gaps, stray rearms and noise bursts
  task automatic send_frames(input int unsigned quota);
    int unsigned start;
    int unsigned pairs;
    logic        mark_lvl;
    start    = samples_sent;
    mark_lvl = cfg_mark;
    while (samples_sent - start < quota) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8))
          send_sample(sample_t'(2'($urandom_range(3))), CHK_PRED, '0);
      end else begin
        if ($urandom_range(5) == 0)
          send_level(!mark_lvl, $urandom_range(1, cfg_gap), $urandom_range(3) != 0);
        else
          send_level(!mark_lvl, cfg_gap + $urandom_range(0, 3), $urandom_range(6) != 0);
        pairs = $urandom_range(1, ($urandom_range(3) == 0) ? 70 : 12);
        for (int unsigned i = 0; i < pairs; i++) begin
          send_level(mark_lvl, $urandom_range(1, cfg_gap + 3), $urandom_range(40) == 0);
          send_level(!mark_lvl, $urandom_range(1, cfg_gap + 1), 1'b0);
        end
        send_level(!mark_lvl, cfg_gap + $urandom_range(2, 4), 1'b0);
      end
    end
  endtask

  // Stop offering, let every due transaction arrive, then let samples that
  // produce nothing pass through the state registers
  task automatic wait_idle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (due_captures.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] gap, input logic [7:0] max_n,
                           input logic mark, input bit squeeze, input int unsigned quota);
    wait_idle();
    set_config(gap, max_n, mark);
    if (squeeze) hold_req = 1'b1;
    send_frames(quota);
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Receiver stalls at random; one long hold-off on request fills the block
  initial begin : rx_drive
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic check_capture(input result_t exp, input result_t act);
    if (act.width_ticks !== exp.width_ticks) begin
      $error("width_ticks: expected %0d, got %0d", exp.width_ticks, act.width_ticks);
      mismatches++;
    end
    if (act.entry_index !== exp.entry_index) begin
      $error("entry_index: expected %0d, got %0d", exp.entry_index, act.entry_index);
      mismatches++;
    end
    if (act.width_kind !== exp.width_kind) begin
      $error("width_kind: expected %0d, got %0d", exp.width_kind, act.width_kind);
      mismatches++;
    end
    if (act.frame_done !== exp.frame_done) begin
      $error("frame_done: expected %0d, got %0d", exp.frame_done, act.frame_done);
      mismatches++;
    end
    if (act.entry_count !== exp.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp.entry_count, act.entry_count);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      captures_seen++;
      if (due_captures.size() == 0) begin
        $error("result transaction with none due: %p", result);
        mismatches++;
      end else begin
        check_capture(due_captures.pop_front(), result);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[ir_pulse_width_capture] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults after reset
    check_reg(REG_GAP_TICKS);
    check_reg(REG_MAX_ENTRIES);
    check_reg(REG_MARK_LEVEL);

    // sender idles lightly, receiver heavily
    tx_idle_pct = 11;
    rx_idle_pct = 71;
    set_config(16'd3, 8'd4, 1'b0);
    foreach (dir_rows[i])
      send_sample('{ir_level: dir_rows[i].lvl, rearm: dir_rows[i].rearm},
                  dir_rows[i].chk, dir_rows[i].typed);

    run_phase(16'd4, 8'd6, 1'b0, 1'b1, 240);
    run_phase(16'd1, 8'd255, 1'b1, 1'b0, 240);   // limit clamps to buffer depth

    // and the other way round
    tx_idle_pct = 71;
    rx_idle_pct = 11;
    run_phase(16'd7, 8'd1, 1'b1, 1'b0, 240);
    run_phase(16'd3, 8'd0, 1'b0, 1'b0, 240);     // zero limit: stop at once

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(16'd2, 8'd128, 1'b0, 1'b0, 240);
    run_phase(16'd6, 8'd20, 1'b1, 1'b0, 240);

    // widest gap: capture can never start from idle
    wait_idle();
    set_config(16'd65535, 8'd88, 1'b0);
    repeat (40) send_sample(sample_t'(2'($urandom_range(3))), CHK_PRED, '0);

    wait_idle();
    repeat (10) @(negedge clk);

    $display("Sent %0d samples over eight register settings; %0d result transactions checked.",
             samples_sent, captures_seen);
    $display("Covered leading gaps, overflow and gap stops, rearm, zero and clamped limits.");
    if (mismatches == 0) begin
      $display("[ir_pulse_width_capture] OK");
    end else begin
      $display("[ir_pulse_width_capture] ERROR");
    end
    $finish;
  end

endmodule
